// ----- design/pcsh_pkg.sv -----
// pcsh_pkg: shared types and constants for the PC sampling histogram.
// Register map, request codes, sequencer states and reset values.
// No dependencies.
`timescale 1ns / 1ps

package pcsh_pkg;

  localparam int DEFAULT_MAX_BINS = 4096;
  localparam int PADDR_W          = 5;
  localparam int PDATA_W          = 32;
  localparam int BIN_IDX_W        = 12;
  localparam int PHASE_W          = 17;
  localparam int RATE_W           = 16;
  localparam int SHIFT_W          = 5;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REGION_NONE   = 2'd0,
    REGION_KERNEL = 2'd1,
    REGION_APP    = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    RI_ENABLE      = 3'd0,
    RI_SAMPLE_RATE = 3'd1,
    RI_TICK_RATE   = 3'd2,
    RI_KERNEL_LOW  = 3'd3,
    RI_KERNEL_HIGH = 3'd4,
    RI_APP_LOW     = 3'd5,
    RI_APP_HIGH    = 3'd6,
    RI_BIN_SHIFT   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_INDEX,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                enable;
    logic [RATE_W-1:0]   sample_rate;
    logic [RATE_W-1:0]   tick_rate;
    logic [31:0]         kernel_low_pc;
    logic [31:0]         kernel_high_pc;
    logic [31:0]         app_low_pc;
    logic [31:0]         app_high_pc;
    logic [SHIFT_W-1:0]  bin_shift;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:         1'b0,
    sample_rate:    16'd1000,
    tick_rate:      16'd1000,
    kernel_low_pc:  32'd0,
    kernel_high_pc: 32'd0,
    app_low_pc:     32'd0,
    app_high_pc:    32'd0,
    bin_shift:      5'd2
  };

endpackage

// ----- design/pc_sample_histogram.sv -----
// pc_sample_histogram: program-counter sampling profiler with a shared bin memory.
// Depends on pcsh_pkg.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_valid / req_stall): req_type selects tick (pc sampled),
//   read of one bin (bin_index), clear of all bins and statistics, or no-op.
//   Result channel (res_valid / res_stall): one beat per request, carrying the
//   bin value, sample flag, hit region and the five statistics after the beat.
//   APB port: eight 32-bit registers at byte address 4*i; pready always high.
// Sequencing
//   Requests are handled one at a time by a sequencer around a single bin
//   memory with a registered read: evaluate, index, read, modify/write-back.
//   A tick, read or no-op reaches the result register from the finish step,
//   and the next request is taken once the sequencer is back in idle.
//   A clear writes one bin per cycle, then loads its result from finish.
// Reset
//   Synchronous rst starts the same walk over every bin, during which
//   req_stall is high. Registers return to their defaults.
// Back-pressure
//   The result register frees the request side; a new request is taken while
//   a result waits. The sequencer only holds in its last step if the previous
//   result is still stalled, so no beat is lost or repeated.

module pc_sample_histogram
  import pcsh_pkg::*;
#(
  parameter int MAX_BINS = DEFAULT_MAX_BINS
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           req_type,
  input  logic [31:0]          pc,
  input  logic [BIN_IDX_W-1:0] bin_index,
  // result channel
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [31:0]          bin_value,
  output logic                 sample_taken,
  output logic [1:0]           hit_region,
  output logic [31:0]          total_count,
  output logic [31:0]          kernel_count,
  output logic [31:0]          app_count,
  output logic [31:0]          unmapped_count,
  output logic [31:0]          saturated_count,
  // APB
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_BINS - 1);

  // ---------------- configuration ----------------
  cfg_t     cfg;
  reg_idx_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_sel)
        RI_ENABLE:      cfg.enable         <= pwdata[0];
        RI_SAMPLE_RATE: cfg.sample_rate    <= pwdata[RATE_W-1:0];
        RI_TICK_RATE:   cfg.tick_rate      <= pwdata[RATE_W-1:0];
        RI_KERNEL_LOW:  cfg.kernel_low_pc  <= pwdata;
        RI_KERNEL_HIGH: cfg.kernel_high_pc <= pwdata;
        RI_APP_LOW:     cfg.app_low_pc     <= pwdata;
        RI_APP_HIGH:    cfg.app_high_pc    <= pwdata;
        RI_BIN_SHIFT:   cfg.bin_shift      <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RI_ENABLE:      prdata = {31'd0, cfg.enable};
      RI_SAMPLE_RATE: prdata = {16'd0, cfg.sample_rate};
      RI_TICK_RATE:   prdata = {16'd0, cfg.tick_rate};
      RI_KERNEL_LOW:  prdata = cfg.kernel_low_pc;
      RI_KERNEL_HIGH: prdata = cfg.kernel_high_pc;
      RI_APP_LOW:     prdata = cfg.app_low_pc;
      RI_APP_HIGH:    prdata = cfg.app_high_pc;
      RI_BIN_SHIFT:   prdata = {27'd0, cfg.bin_shift};
      default:        prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  state_t state, state_next;

  logic [IDX_W-1:0] clr_addr;
  logic             clr_item;

  req_t                 req_q;
  logic [31:0]          pc_q;
  logic [BIN_IDX_W-1:0] bidx_q;

  logic [PHASE_W-1:0] phase;
  logic [31:0] total_samples, kernel_samples, app_samples;
  logic [31:0] unmapped_samples, saturated_samples;

  // evaluate stage
  logic        taken_q, khit_q, ahit_q;
  logic [32:0] koff_q, aoff_q, kspan_q;
  // index stage
  logic [33:0] idx_q;
  // lookup stage
  logic        rec_q, read_ok_q;

  // memory
  logic [31:0]      mem [MAX_BINS];
  logic [31:0]      rd_data;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  logic [31:0]      mem_wdata;

  logic accept, commit, out_free;

  assign accept   = req_valid && !req_stall;
  assign out_free = !res_valid || !res_stall;

  // ---------------- evaluate datapath ----------------
  logic [SHIFT_W-1:0] sh;
  logic [32:0]        msk, kbase, kend, abase;
  logic [RATE_W-1:0]  inc;
  logic [PHASE_W-1:0] phase_sum;
  logic               tick_en;

  assign sh        = (cfg.bin_shift > SHIFT_MAX) ? SHIFT_MAX : cfg.bin_shift;
  assign msk       = (33'd1 << sh) - 33'd1;
  assign kbase     = {1'b0, cfg.kernel_low_pc} & ~msk;
  assign kend      = ({1'b0, cfg.kernel_high_pc} + msk) & ~msk;
  assign abase     = {1'b0, cfg.app_low_pc} & ~msk;
  assign inc       = (cfg.sample_rate < cfg.tick_rate) ? cfg.sample_rate : cfg.tick_rate;
  assign phase_sum = phase + PHASE_W'(inc);
  assign tick_en   = (req_q == REQ_TICK) && cfg.enable;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_t'(req_type);
      pc_q   <= pc;
      bidx_q <= bin_index;
    end
    if (state == ST_EVAL) begin
      taken_q <= tick_en && (phase_sum >= PHASE_W'(cfg.tick_rate));
      khit_q  <= (pc_q >= cfg.kernel_low_pc) && (pc_q < cfg.kernel_high_pc);
      ahit_q  <= (pc_q >= cfg.app_low_pc) && (pc_q < cfg.app_high_pc);
      koff_q  <= {1'b0, pc_q} - kbase;
      aoff_q  <= {1'b0, pc_q} - abase;
      kspan_q <= (kend > kbase) ? (kend - kbase) : 33'd0;
    end
    if (state == ST_INDEX) begin
      idx_q <= khit_q ? 34'(koff_q >> sh) : (34'(kspan_q >> sh) + 34'(aoff_q >> sh));
    end
    if (state == ST_LOOKUP) begin
      rec_q     <= taken_q && (khit_q || ahit_q) && (idx_q < 34'(MAX_BINS));
      read_ok_q <= 32'(bidx_q) < 32'(MAX_BINS);
    end
  end

  // phase: advanced when a tick is evaluated while enabled, zeroed by a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (state == ST_EVAL && tick_en) begin
      phase <= (phase_sum >= PHASE_W'(cfg.tick_rate))
             ? phase_sum - PHASE_W'(cfg.tick_rate) : phase_sum;
    end else if (commit && req_q == REQ_CLEAR) begin
      phase <= '0;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == LAST_ADDR) state_next = clr_item ? ST_FINISH : ST_IDLE;
      ST_IDLE:   if (accept) state_next = (req_type == REQ_CLEAR) ? ST_CLEAR : ST_EVAL;
      ST_EVAL:   state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      clr_item <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + IDX_W'(1);
        if (clr_addr == LAST_ADDR) clr_item <= 1'b0;
      end
      if (accept && req_type == REQ_CLEAR) clr_item <= 1'b1;
    end
  end

  // ---------------- control outputs ----------------
  logic sat;
  assign sat = (rd_data == 32'hFFFF_FFFF);

  always_comb begin
    req_stall = 1'b1;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    commit    = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_IDLE: req_stall = 1'b0;
      ST_LOOKUP: begin
        mem_re    = 1'b1;
        mem_raddr = (req_q == REQ_TICK) ? idx_q[IDX_W-1:0] : IDX_W'(bidx_q);
      end
      ST_FINISH: begin
        commit    = out_free;
        mem_we    = out_free && (req_q == REQ_TICK) && rec_q && !sat;
        mem_waddr = idx_q[IDX_W-1:0];
        mem_wdata = rd_data + 32'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // ---------------- statistics and result ----------------
  logic [31:0] tot_n, ker_n, app_n, unm_n, sat_n;
  logic        is_tick;

  assign is_tick = (req_q == REQ_TICK);

  always_comb begin
    tot_n = total_samples;
    ker_n = kernel_samples;
    app_n = app_samples;
    unm_n = unmapped_samples;
    sat_n = saturated_samples;
    case (req_q)
      REQ_TICK: begin
        if (taken_q) begin
          tot_n = total_samples + 32'd1;
          if (!rec_q) begin
            unm_n = unmapped_samples + 32'd1;
          end else begin
            if (sat) sat_n = saturated_samples + 32'd1;
            if (khit_q) ker_n = kernel_samples + 32'd1;
            else        app_n = app_samples + 32'd1;
          end
        end
      end
      REQ_CLEAR: begin
        tot_n = '0;
        ker_n = '0;
        app_n = '0;
        unm_n = '0;
        sat_n = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_samples     <= '0;
      kernel_samples    <= '0;
      app_samples       <= '0;
      unmapped_samples  <= '0;
      saturated_samples <= '0;
    end else if (commit) begin
      total_samples     <= tot_n;
      kernel_samples    <= ker_n;
      app_samples       <= app_n;
      unmapped_samples  <= unm_n;
      saturated_samples <= sat_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      bin_value       <= (req_q == REQ_READ && read_ok_q) ? rd_data : 32'd0;
      sample_taken    <= is_tick && taken_q;
      hit_region      <= (is_tick && rec_q)
                       ? (khit_q ? REGION_KERNEL : REGION_APP) : REGION_NONE;
      total_count     <= tot_n;
      kernel_count    <= ker_n;
      app_count       <= app_n;
      unmapped_count  <= unm_n;
      saturated_count <= sat_n;
    end
  end

  // ---------------- assertions ----------------
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem_we)
    else $error("bin memory written while idle");

  a_accept_advances: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EVAL || state == ST_CLEAR))
    else $error("accepted beat not taken up by sequencer");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish step");

  a_incr_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_FINISH) |-> mem_wdata != 32'd0)
    else $error("bin counter wrapped");

  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    commit |=> res_valid && state == ST_IDLE)
    else $error("commit did not load result");

endmodule
